@@ sv/rsapm_pkg.sv @@
// ============================================================================
// rsapm_pkg: shared types and constants for the RSA public modexp block
// Word widths, register map, operand sources, sequencer states and the
// product schedule for the two public exponents.
// ============================================================================
package rsapm_pkg;

    // Field widths
    localparam int WORD_W       = 32;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int PADDR_W      = 4;
    localparam int OP_W         = 5;
    localparam int MAX_WORDS_DEF = 64;
    localparam int F4_SQUARINGS = 16;

    // Register map (index = paddr[3:2])
    localparam logic [1:0] REG_WORD_COUNT = 2'd0;
    localparam logic [1:0] REG_INV_MOD    = 2'd1;
    localparam logic [1:0] REG_EXP_SEL    = 2'd2;

    // Reset values
    localparam logic [CNT_W-1:0]  WC_RESET  = 7'd64;
    localparam logic [WORD_W-1:0] INV_RESET = 32'd1;
    localparam logic              EXP_RESET = 1'b1;

    // Operand sources of a Montgomery product
    typedef enum logic [2:0] {
        SRC_BASE,
        SRC_RSQ,
        SRC_MB,
        SRC_SQ,
        SRC_ONE
    } src_t;

    // One Montgomery product: dst = a * b / R mod N
    typedef struct packed {
        src_t a_src;
        src_t b_src;
        logic dst_sq;
        logic last;
    } op_t;

    // Datapath work modes
    typedef enum logic [2:0] {
        MD_MUB0,
        MD_Q,
        MD_INNER,
        MD_FIN,
        MD_COPY
    } mode_t;

    // Sequencer to datapath control
    typedef struct packed {
        logic             issue;
        mode_t            mode;
        logic [CNT_W-1:0] k;
        logic             last;
        logic             first_row;
        logic             b_one;
    } ctl_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OP_START,
        ST_MUB0_WAIT,
        ST_ROW_RD,
        ST_ROW_WAIT,
        ST_INNER,
        ST_DRAIN,
        ST_FIN,
        ST_FIN_WAIT,
        ST_COPY,
        ST_COPY_WAIT,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_WAIT
    } state_t;

    // Product schedule. Step 0 maps the message into the Montgomery domain.
    // Exponent 3: square, multiply, leave the domain by a product with one.
    // Exponent 65537: sixteen squarings, then a product with the plain message.
    function automatic op_t op_lookup(input logic exp_sel, input logic [OP_W-1:0] op_num);
        op_t op;
        op = '{a_src: SRC_MB, b_src: SRC_BASE, dst_sq: 1'b1, last: 1'b1};
        if (op_num == '0) begin
            op = '{a_src: SRC_BASE, b_src: SRC_RSQ, dst_sq: 1'b0, last: 1'b0};
        end else if (!exp_sel) begin
            if (op_num == OP_W'(1)) begin
                op = '{a_src: SRC_MB, b_src: SRC_MB, dst_sq: 1'b1, last: 1'b0};
            end else if (op_num == OP_W'(2)) begin
                op = '{a_src: SRC_SQ, b_src: SRC_MB, dst_sq: 1'b0, last: 1'b0};
            end else begin
                op = '{a_src: SRC_MB, b_src: SRC_ONE, dst_sq: 1'b1, last: 1'b1};
            end
        end else if (op_num <= OP_W'(F4_SQUARINGS)) begin
            if (op_num[0]) begin
                op = '{a_src: SRC_MB, b_src: SRC_MB, dst_sq: 1'b1, last: 1'b0};
            end else begin
                op = '{a_src: SRC_SQ, b_src: SRC_SQ, dst_sq: 1'b0, last: 1'b0};
            end
        end
        return op;
    endfunction

endpackage

@@ sv/rsapm_ram.sv @@
// ============================================================================
// rsapm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ============================================================================
module rsapm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/rsapm_cfg.sv @@
// ============================================================================
// rsapm_cfg: APB configuration registers
// word_count, inverse_modulus and exponent_select, readable and writable.
// ============================================================================
module rsapm_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsapm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [rsapm_pkg::CNT_W-1:0]   word_count,
    output logic [rsapm_pkg::WORD_W-1:0]  inv_mod,
    output logic                          exp_sel
);

    logic [rsapm_pkg::CNT_W-1:0]  wc_reg;
    logic [rsapm_pkg::WORD_W-1:0] inv_reg;
    logic                         exp_reg;
    logic                         wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite & pready;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wc_reg  <= rsapm_pkg::WC_RESET;
            inv_reg <= rsapm_pkg::INV_RESET;
            exp_reg <= rsapm_pkg::EXP_RESET;
        end else if (wr) begin
            unique case (paddr[3:2])
                rsapm_pkg::REG_WORD_COUNT: wc_reg  <= pwdata[rsapm_pkg::CNT_W-1:0];
                rsapm_pkg::REG_INV_MOD:    inv_reg <= pwdata;
                rsapm_pkg::REG_EXP_SEL:    exp_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[3:2])
            rsapm_pkg::REG_WORD_COUNT: prdata = {{(32 - rsapm_pkg::CNT_W){1'b0}}, wc_reg};
            rsapm_pkg::REG_INV_MOD:    prdata = inv_reg;
            rsapm_pkg::REG_EXP_SEL:    prdata = {31'b0, exp_reg};
            default:                   prdata = '0;
        endcase
    end

    assign word_count = wc_reg;
    assign inv_mod    = inv_reg;
    assign exp_sel    = exp_reg;

endmodule

@@ sv/rsapm_mac.sv @@
// ============================================================================
// rsapm_mac: Montgomery multiply-accumulate datapath
// Two 32x32 multipliers, split d/e carry chains, the final borrow/carry pass
// and the conditional copy into the destination store.
// ============================================================================
module rsapm_mac (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rsapm_pkg::ctl_t               ctl,
    input  logic [rsapm_pkg::WORD_W-1:0]  a_word,
    input  logic [rsapm_pkg::WORD_W-1:0]  b_word,
    input  logic [rsapm_pkg::WORD_W-1:0]  n_word,
    input  logic [2*rsapm_pkg::WORD_W-1:0] acc_word,
    input  logic [rsapm_pkg::WORD_W-1:0]  inv_mod,
    input  logic [rsapm_pkg::CNT_W-1:0]   cnt,
    output logic                          acc_we,
    output logic [rsapm_pkg::CNT_W-1:0]   acc_waddr,
    output logic [2*rsapm_pkg::WORD_W-1:0] acc_wdata,
    output logic                          dst_we,
    output logic [rsapm_pkg::CNT_W-1:0]   dst_waddr,
    output logic [rsapm_pkg::WORD_W-1:0]  dst_wdata,
    output logic                          busy
);

    // control pipeline
    logic                        v1_reg, v2_reg, tail_reg;
    rsapm_pkg::mode_t            mode1_reg, mode2_reg;
    logic [rsapm_pkg::CNT_W-1:0] k1_reg, k2_reg;
    logic                        last1_reg, last2_reg, first1_reg, bone1_reg;

    // datapath registers
    logic [31:0] mub0_reg, q_reg, aj_reg, c0_reg, c1_reg, d2_reg, e2_reg;
    logic [63:0] pa_reg, pb_reg;
    logic        borrow_reg, carry_reg;

    logic [31:0] b_val, d_val, e_val;
    logic [31:0] ma_x, ma_y, mb_x, mb_y;
    logic        bin, cin;
    logic [32:0] diff, sum;
    logic [31:0] cin0, cin1;
    logic [63:0] p0, p1;

    // stage 1 operand select
    always_comb begin
        b_val = bone1_reg ? {31'b0, (k1_reg == '0)} : b_word;
        d_val = first1_reg ? '0 : acc_word[63:32];
        e_val = first1_reg ? '0 : acc_word[31:0];
        ma_x  = '0;
        ma_y  = '0;
        mb_x  = '0;
        mb_y  = '0;
        case (mode1_reg)
            rsapm_pkg::MD_MUB0: begin
                ma_x = inv_mod;
                ma_y = b_val;
            end
            rsapm_pkg::MD_Q: begin
                ma_x = inv_mod;
                ma_y = d_val - e_val;
                mb_x = mub0_reg;
                mb_y = a_word;
            end
            rsapm_pkg::MD_INNER: begin
                ma_x = aj_reg;
                ma_y = b_val;
                mb_x = q_reg;
                mb_y = n_word;
            end
            default: ;
        endcase
    end

    // final pass: d - e with borrow, and (d - e) + N with carry
    always_comb begin
        bin  = (k1_reg == '0) ? 1'b0 : borrow_reg;
        cin  = (k1_reg == '0) ? 1'b0 : carry_reg;
        diff = {1'b0, acc_word[63:32]} - {1'b0, acc_word[31:0]} - {32'b0, bin};
        sum  = {1'b0, diff[31:0]} + {1'b0, n_word} + {32'b0, cin};
    end

    // stage 2 accumulate with carries
    always_comb begin
        cin0 = (k2_reg == '0) ? '0 : c0_reg;
        cin1 = (k2_reg == '0) ? '0 : c1_reg;
        p0   = pa_reg + {32'b0, d2_reg} + {32'b0, cin0};
        p1   = pb_reg + {32'b0, e2_reg} + {32'b0, cin1};
    end

    // accumulator write port
    always_comb begin
        acc_we    = 1'b0;
        acc_waddr = '0;
        acc_wdata = '0;
        if (v2_reg && mode2_reg == rsapm_pkg::MD_INNER && k2_reg != '0) begin
            acc_we    = 1'b1;
            acc_waddr = k2_reg - 1'b1;
            acc_wdata = {p0[31:0], p1[31:0]};
        end else if (tail_reg) begin
            acc_we    = 1'b1;
            acc_waddr = cnt - 1'b1;
            acc_wdata = {c0_reg, c1_reg};
        end else if (v1_reg && mode1_reg == rsapm_pkg::MD_FIN) begin
            acc_we    = 1'b1;
            acc_waddr = k1_reg;
            acc_wdata = {diff[31:0], sum[31:0]};
        end
    end

    // destination copy: sum if the subtraction borrowed, else difference
    assign dst_we    = v1_reg && mode1_reg == rsapm_pkg::MD_COPY;
    assign dst_waddr = k1_reg;
    assign dst_wdata = borrow_reg ? acc_word[31:0] : acc_word[63:32];

    assign busy = v1_reg | v2_reg | tail_reg;

    // control valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            tail_reg <= 1'b0;
        end else begin
            v1_reg   <= ctl.issue;
            v2_reg   <= v1_reg && (mode1_reg == rsapm_pkg::MD_MUB0 ||
                                   mode1_reg == rsapm_pkg::MD_Q ||
                                   mode1_reg == rsapm_pkg::MD_INNER);
            tail_reg <= v2_reg && mode2_reg == rsapm_pkg::MD_INNER && last2_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        mode1_reg  <= ctl.mode;
        k1_reg     <= ctl.k;
        last1_reg  <= ctl.last;
        first1_reg <= ctl.first_row;
        bone1_reg  <= ctl.b_one;
        mode2_reg  <= mode1_reg;
        k2_reg     <= k1_reg;
        last2_reg  <= last1_reg;
        pa_reg     <= {32'b0, ma_x} * {32'b0, ma_y};
        pb_reg     <= {32'b0, mb_x} * {32'b0, mb_y};
        d2_reg     <= d_val;
        e2_reg     <= e_val;
        if (v1_reg && mode1_reg == rsapm_pkg::MD_Q) begin
            aj_reg <= a_word;
        end
        if (v1_reg && mode1_reg == rsapm_pkg::MD_FIN) begin
            borrow_reg <= diff[32];
            carry_reg  <= sum[32];
        end
        if (v2_reg) begin
            case (mode2_reg)
                rsapm_pkg::MD_MUB0: mub0_reg <= pa_reg[31:0];
                rsapm_pkg::MD_Q:    q_reg    <= pa_reg[31:0] + pb_reg[31:0];
                rsapm_pkg::MD_INNER: begin
                    c0_reg <= p0[63:32];
                    c1_reg <= p1[63:32];
                end
                default: ;
            endcase
        end
    end

endmodule

@@ sv/rsa_public_modexp_montgomery.sv @@
// ============================================================================
// rsa_public_modexp_montgomery: RSA public exponent modexp, Montgomery form
// Loads N, R^2 mod N and the message word by word, raises the message to
// 3 or 65537 and returns the result words most significant first.
// ============================================================================
//
//  channel  | ports              | moves
//  ---------+--------------------+----------------------------------------
//  s_       | s_valid / s_ready  | one load transaction (word of N, R2, M)
//  m_       | m_valid / m_ready  | one result word transaction
//  apb      | psel/penable/...   | register write or read
//
//  The load transaction with load_last starts the exponentiation: word
//  columns pass one per cycle within a row through the multiplier pair and
//  the accumulator memory port; 4 products for exponent 3, 18 for 65537.
//  Each result word passes the read, load and wait states and is held
//  until m_ready; the next word is read only after it is taken.
//  No clearing pass after reset. s_ready is high only while idle.
//
module rsa_public_modexp_montgomery #(
    parameter int MAX_WORDS = rsapm_pkg::MAX_WORDS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rsapm_pkg::IDX_W-1:0]   s_word_index,
    input  logic [rsapm_pkg::WORD_W-1:0]  s_modulus_word,
    input  logic [rsapm_pkg::WORD_W-1:0]  s_rsquare_word,
    input  logic [rsapm_pkg::WORD_W-1:0]  s_message_word,
    input  logic                          s_load_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rsapm_pkg::WORD_W-1:0]  m_result_word,
    output logic [rsapm_pkg::IDX_W-1:0]   m_result_index,
    output logic                          m_result_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsapm_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW = rsapm_pkg::CNT_W;

    // configuration
    logic [CW-1:0] word_count;
    logic [31:0]   inv_mod;
    logic          exp_sel;

    rsapm_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .word_count (word_count),
        .inv_mod    (inv_mod),
        .exp_sel    (exp_sel)
    );

    // effective word count, saturated to 1..MAX_WORDS
    logic [CW-1:0] cnt, cnt_m1;
    always_comb begin
        if (word_count == '0) begin
            cnt = CW'(1);
        end else if (word_count > CW'(MAX_WORDS)) begin
            cnt = CW'(MAX_WORDS);
        end else begin
            cnt = word_count;
        end
        cnt_m1 = cnt - 1'b1;
    end

    // sequencer state
    rsapm_pkg::state_t state_reg, state_next;
    logic [CW-1:0]     j_reg, j_next, k_reg, k_next;
    logic [rsapm_pkg::OP_W-1:0] op_reg, op_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_load;
    rsapm_pkg::op_t    cur_op;
    rsapm_pkg::ctl_t   ctl;

    // memory ports
    logic        ld_we, mb_we, sq_we, acc_we, dst_we, mac_busy;
    logic [95:0] ld_rdata;
    logic [31:0] mb_rdata, sq_rdata, a_word, b_word, dst_wdata;
    logic [63:0] acc_rdata, acc_wdata;
    logic [CW-1:0] acc_waddr, dst_waddr;
    logic [AW-1:0] ld_raddr, mb_raddr, sq_raddr;
    logic        idx_ok;

    logic [31:0] res_word_reg;
    logic [rsapm_pkg::IDX_W-1:0] res_idx_reg;
    logic        res_last_reg;

    assign cur_op = rsapm_pkg::op_lookup(exp_sel, op_reg);
    assign idx_ok = {1'b0, s_word_index} < cnt;
    assign s_ready = (state_reg == rsapm_pkg::ST_IDLE);
    assign ld_we  = s_valid & s_ready & idx_ok;

    // read addresses: the a operand is fetched at row index j, all else at k
    always_comb begin
        ld_raddr = k_reg[AW-1:0];
        mb_raddr = k_reg[AW-1:0];
        sq_raddr = k_reg[AW-1:0];
        if (state_reg == rsapm_pkg::ST_ROW_RD) begin
            case (cur_op.a_src)
                rsapm_pkg::SRC_BASE: ld_raddr = j_reg[AW-1:0];
                rsapm_pkg::SRC_MB:   mb_raddr = j_reg[AW-1:0];
                rsapm_pkg::SRC_SQ:   sq_raddr = j_reg[AW-1:0];
                default: ;
            endcase
        end
    end

    // operand routing
    always_comb begin
        case (cur_op.a_src)
            rsapm_pkg::SRC_BASE: a_word = ld_rdata[31:0];
            rsapm_pkg::SRC_MB:   a_word = mb_rdata;
            rsapm_pkg::SRC_SQ:   a_word = sq_rdata;
            default:             a_word = '0;
        endcase
        case (cur_op.b_src)
            rsapm_pkg::SRC_BASE: b_word = ld_rdata[31:0];
            rsapm_pkg::SRC_RSQ:  b_word = ld_rdata[63:32];
            rsapm_pkg::SRC_MB:   b_word = mb_rdata;
            rsapm_pkg::SRC_SQ:   b_word = sq_rdata;
            default:             b_word = '0;
        endcase
    end

    assign mb_we = dst_we & ~cur_op.dst_sq;
    assign sq_we = dst_we & cur_op.dst_sq;

    // load store: {N, R2, message}
    rsapm_ram #(.WIDTH(96), .DEPTH(MAX_WORDS)) u_ld_ram (
        .aclk  (aclk),
        .we    (ld_we),
        .waddr (s_word_index[AW-1:0]),
        .wdata ({s_modulus_word, s_rsquare_word, s_message_word}),
        .raddr (ld_raddr),
        .rdata (ld_rdata)
    );

    rsapm_ram #(.WIDTH(32), .DEPTH(MAX_WORDS)) u_mb_ram (
        .aclk  (aclk),
        .we    (mb_we),
        .waddr (dst_waddr[AW-1:0]),
        .wdata (dst_wdata),
        .raddr (mb_raddr),
        .rdata (mb_rdata)
    );

    rsapm_ram #(.WIDTH(32), .DEPTH(MAX_WORDS)) u_sq_ram (
        .aclk  (aclk),
        .we    (sq_we),
        .waddr (dst_waddr[AW-1:0]),
        .wdata (dst_wdata),
        .raddr (sq_raddr),
        .rdata (sq_rdata)
    );

    // split accumulators {d, e}
    rsapm_ram #(.WIDTH(64), .DEPTH(MAX_WORDS)) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (acc_waddr[AW-1:0]),
        .wdata (acc_wdata),
        .raddr (k_reg[AW-1:0]),
        .rdata (acc_rdata)
    );

    rsapm_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .a_word    (a_word),
        .b_word    (b_word),
        .n_word    (ld_rdata[95:64]),
        .acc_word  (acc_rdata),
        .inv_mod   (inv_mod),
        .cnt       (cnt),
        .acc_we    (acc_we),
        .acc_waddr (acc_waddr),
        .acc_wdata (acc_wdata),
        .dst_we    (dst_we),
        .dst_waddr (dst_waddr),
        .dst_wdata (dst_wdata),
        .busy      (mac_busy)
    );

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rsapm_pkg::ST_IDLE;
            j_reg       <= '0;
            k_reg       <= '0;
            op_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state and issue control
    always_comb begin
        state_next    = state_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        op_next       = op_reg;
        m_valid_next  = m_valid_reg;
        out_load      = 1'b0;
        ctl.issue     = 1'b0;
        ctl.mode      = rsapm_pkg::MD_INNER;
        ctl.k         = k_reg;
        ctl.last      = (k_reg == cnt_m1);
        ctl.first_row = (j_reg == '0);
        ctl.b_one     = (cur_op.b_src == rsapm_pkg::SRC_ONE);
        unique case (state_reg)
            rsapm_pkg::ST_IDLE: begin
                if (s_valid && idx_ok && s_load_last) begin
                    op_next    = '0;
                    k_next     = '0;
                    state_next = rsapm_pkg::ST_OP_START;
                end
            end
            rsapm_pkg::ST_OP_START: begin
                ctl.issue  = 1'b1;
                ctl.mode   = rsapm_pkg::MD_MUB0;
                state_next = rsapm_pkg::ST_MUB0_WAIT;
            end
            rsapm_pkg::ST_MUB0_WAIT: begin
                if (!mac_busy) begin
                    j_next     = '0;
                    state_next = rsapm_pkg::ST_ROW_RD;
                end
            end
            rsapm_pkg::ST_ROW_RD: begin
                ctl.issue  = 1'b1;
                ctl.mode   = rsapm_pkg::MD_Q;
                state_next = rsapm_pkg::ST_ROW_WAIT;
            end
            rsapm_pkg::ST_ROW_WAIT: begin
                if (!mac_busy) begin
                    state_next = rsapm_pkg::ST_INNER;
                end
            end
            rsapm_pkg::ST_INNER: begin
                ctl.issue = 1'b1;
                ctl.mode  = rsapm_pkg::MD_INNER;
                if (k_reg == cnt_m1) begin
                    k_next     = '0;
                    state_next = rsapm_pkg::ST_DRAIN;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            rsapm_pkg::ST_DRAIN: begin
                if (!mac_busy) begin
                    if (j_reg == cnt_m1) begin
                        state_next = rsapm_pkg::ST_FIN;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = rsapm_pkg::ST_ROW_RD;
                    end
                end
            end
            rsapm_pkg::ST_FIN: begin
                ctl.issue = 1'b1;
                ctl.mode  = rsapm_pkg::MD_FIN;
                if (k_reg == cnt_m1) begin
                    k_next     = '0;
                    state_next = rsapm_pkg::ST_FIN_WAIT;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            rsapm_pkg::ST_FIN_WAIT: begin
                if (!mac_busy) begin
                    state_next = rsapm_pkg::ST_COPY;
                end
            end
            rsapm_pkg::ST_COPY: begin
                ctl.issue = 1'b1;
                ctl.mode  = rsapm_pkg::MD_COPY;
                if (k_reg == cnt_m1) begin
                    k_next     = '0;
                    state_next = rsapm_pkg::ST_COPY_WAIT;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            rsapm_pkg::ST_COPY_WAIT: begin
                if (!mac_busy) begin
                    if (cur_op.last) begin
                        k_next     = cnt_m1;
                        state_next = rsapm_pkg::ST_OUT_RD;
                    end else begin
                        op_next    = op_reg + 1'b1;
                        state_next = rsapm_pkg::ST_OP_START;
                    end
                end
            end
            rsapm_pkg::ST_OUT_RD: begin
                state_next = rsapm_pkg::ST_OUT_LOAD;
            end
            rsapm_pkg::ST_OUT_LOAD: begin
                out_load     = 1'b1;
                m_valid_next = 1'b1;
                state_next   = rsapm_pkg::ST_OUT_WAIT;
            end
            rsapm_pkg::ST_OUT_WAIT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (k_reg == '0) begin
                        state_next = rsapm_pkg::ST_IDLE;
                    end else begin
                        k_next     = k_reg - 1'b1;
                        state_next = rsapm_pkg::ST_OUT_RD;
                    end
                end
            end
            default: state_next = rsapm_pkg::ST_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            res_word_reg <= sq_rdata;
            res_idx_reg  <= k_reg[rsapm_pkg::IDX_W-1:0];
            res_last_reg <= (k_reg == '0);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_word  = res_word_reg;
    assign m_result_index = res_idx_reg;
    assign m_result_last  = res_last_reg;

`ifndef ASSERT_OFF
    // loads are taken only with the datapath drained
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mac_busy)
        else $error("load accepted while datapath busy");

    // results are presented only from the output wait state
    a_valid_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> state_reg == rsapm_pkg::ST_OUT_WAIT)
        else $error("result valid outside output state");

    // the final word carries index zero
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_last) |-> m_result_index == '0)
        else $error("last word with nonzero index");

    // after the final word the block returns to idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_result_last) |=> s_ready)
        else $error("not idle after final word");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking testbench for rsa_public_modexp_montgomery
// Loads N, R^2 mod N and message words over the valid/ready load channel,
// programs the registers over APB between operations, and checks every
// result word against a word-level Montgomery model kept in the testbench.
// ============================================================================
module tb;

    typedef logic [rsapm_pkg::WORD_W-1:0] vec_t [64];

    typedef struct {
        logic [rsapm_pkg::WORD_W-1:0] word;
        logic [rsapm_pkg::IDX_W-1:0]  index;
        logic                         last;
    } res_t;

    // Directed stimulus row; cfg rows program the registers first
    typedef struct {
        bit                          cfg;
        logic [rsapm_pkg::CNT_W-1:0] wc;
        logic [31:0]                 mu;
        bit                          ex;
        logic [rsapm_pkg::IDX_W-1:0] idx;
        logic [31:0]                 n;
        logic [31:0]                 r2;
        logic [31:0]                 msg;
        bit                          last;
        bit                          typed;
        logic [31:0]                 exp_word;
    } row_t;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int ITEM_TARGET    = 420;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [rsapm_pkg::IDX_W-1:0]     s_word_index;
    logic [rsapm_pkg::WORD_W-1:0]    s_modulus_word;
    logic [rsapm_pkg::WORD_W-1:0]    s_rsquare_word;
    logic [rsapm_pkg::WORD_W-1:0]    s_message_word;
    logic                            s_load_last;
    logic                            m_valid;
    logic                            m_ready;
    logic [rsapm_pkg::WORD_W-1:0]    m_result_word;
    logic [rsapm_pkg::IDX_W-1:0]     m_result_index;
    logic                            m_result_last;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [rsapm_pkg::PADDR_W-1:0]   paddr;
    logic [31:0]                     pwdata;
    logic [31:0]                     prdata;
    logic                            pready;

    rsa_public_modexp_montgomery u_top (.*);

    // Model state: register mirror and word stores
    logic [rsapm_pkg::CNT_W-1:0]  wc_reg;
    logic [31:0]                  mu_reg;
    logic                         exp_reg;
    vec_t                         mod_mem, rsq_mem, msg_mem, mb_mem, sq_mem;
    bit [63:0]                    loaded;

    res_t  result_q[$];
    int    errors;
    int    items_sent;
    int    tx_idle_pct;
    int    rx_stall_pct;
    int    idle_cycles;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int eff_count();
        if (wc_reg == 0) return 1;
        if (wc_reg > 64) return 64;
        return int'(wc_reg);
    endfunction

    // a * b / R mod N with split product and reduction accumulators
    function automatic vec_t mont_product(vec_t a, vec_t b, int cnt);
        vec_t        d, e;
        logic [31:0] mub0, aj, low, q, c0, c1, t, carry;
        logic [63:0] p0, p1, s;
        logic        borrow;
        for (int k = 0; k < 64; k++) begin
            d[k] = '0;
            e[k] = '0;
        end
        mub0 = mu_reg * b[0];
        for (int j = 0; j < cnt; j++) begin
            aj  = a[j];
            low = d[0] - e[0];
            q   = mu_reg * low + mub0 * aj;
            p0  = 64'(aj) * 64'(b[0]) + 64'(d[0]);
            p1  = 64'(q) * 64'(mod_mem[0]) + 64'(e[0]);
            c0  = p0[63:32];
            c1  = p1[63:32];
            for (int k = 1; k < cnt; k++) begin
                p0 = 64'(aj) * 64'(b[k]) + 64'(c0) + 64'(d[k]);
                c0 = p0[63:32];
                d[k-1] = p0[31:0];
                p1 = 64'(q) * 64'(mod_mem[k]) + 64'(c1) + 64'(e[k]);
                c1 = p1[63:32];
                e[k-1] = p1[31:0];
            end
            d[cnt-1] = c0;
            e[cnt-1] = c1;
        end
        // d - e, and d - e + N, both computed; pick on borrow
        borrow = 1'b0;
        for (int k = 0; k < cnt; k++) begin
            t = d[k] - e[k] - 32'(borrow);
            borrow = d[k][31] ^ ((d[k][31] ^ e[k][31]) | (d[k][31] ^ t[31]));
            d[k] = t;
        end
        carry = '0;
        for (int k = 0; k < cnt; k++) begin
            s = 64'(d[k]) + 64'(mod_mem[k]) + 64'(carry);
            carry = s[63:32];
            e[k] = s[31:0];
        end
        return borrow ? e : d;
    endfunction

    // Apply one accepted load; on load_last run the exponent and queue words
    task automatic apply_load(input logic [rsapm_pkg::IDX_W-1:0] idx,
                              input logic [31:0] n,
                              input logic [31:0] r2, input logic [31:0] msg,
                              input bit last, input bit push);
        int   cnt;
        vec_t one_v;
        res_t r;
        cnt = eff_count();
        if (int'(idx) >= cnt) return;
        mod_mem[idx] = n;
        rsq_mem[idx] = r2;
        msg_mem[idx] = msg;
        loaded[idx]  = 1'b1;
        if (!last) return;
        mb_mem = mont_product(msg_mem, rsq_mem, cnt);
        if (!exp_reg) begin
            for (int k = 0; k < 64; k++) one_v[k] = '0;
            one_v[0] = 32'd1;
            sq_mem = mont_product(mb_mem, mb_mem, cnt);
            mb_mem = mont_product(sq_mem, mb_mem, cnt);
            sq_mem = mont_product(mb_mem, one_v, cnt);
        end else begin
            for (int k = 0; k < rsapm_pkg::F4_SQUARINGS; k += 2) begin
                sq_mem = mont_product(mb_mem, mb_mem, cnt);
                mb_mem = mont_product(sq_mem, sq_mem, cnt);
            end
            sq_mem = mont_product(mb_mem, msg_mem, cnt);
        end
        if (!push) return;
        for (int k = cnt - 1; k >= 0; k--) begin
            r.word  = sq_mem[k];
            r.index = rsapm_pkg::IDX_W'(k);
            r.last  = (k == 0);
            result_q.push_back(r);
        end
    endtask

    // One load transaction; entered and left at a rising edge
    task automatic send_load(input logic [rsapm_pkg::IDX_W-1:0] idx,
                             input logic [31:0] n,
                             input logic [31:0] r2, input logic [31:0] msg,
                             input bit last, input bit push);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_word_index   <= idx;
        s_modulus_word <= n;
        s_rsquare_word <= r2;
        s_message_word <= msg;
        s_load_last    <= last;
        do @(posedge aclk); while (!s_ready);
        apply_load(idx, n, r2, msg, last, push);
        if (int'(idx) < eff_count()) items_sent++;
    endtask

    task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (reg_idx)
            rsapm_pkg::REG_WORD_COUNT: wc_reg  = value[rsapm_pkg::CNT_W-1:0];
            rsapm_pkg::REG_INV_MOD:    mu_reg  = value;
            rsapm_pkg::REG_EXP_SEL:    exp_reg = value[0];
            default: ;
        endcase
    endtask

    // Drop valid, drain results, let the block settle, then program registers
    task automatic configure(input logic [rsapm_pkg::CNT_W-1:0] wc,
                             input logic [31:0] mu, input bit ex);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        apb_write(rsapm_pkg::REG_WORD_COUNT, 32'(wc));
        apb_write(rsapm_pkg::REG_INV_MOD, mu);
        apb_write(rsapm_pkg::REG_EXP_SEL, 32'(ex));
    endtask

    function automatic logic [31:0] inv32(input logic [31:0] n0);
        logic [31:0] x;
        x = n0;
        repeat (5) x = x * (32'd2 - n0 * x);
        return x;
    endfunction

    // Result checker
    always @(posedge aclk) begin
        res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (result_q.size() == 0) begin
                $display("%0t: unexpected result word %h index %0d", $realtime,
                         m_result_word, m_result_index);
                errors++;
            end else begin
                e = result_q.pop_front();
                if (m_result_word !== e.word) begin
                    $display("%0t: result_word expected %h actual %h", $realtime,
                             e.word, m_result_word);
                    errors++;
                end
                if (m_result_index !== e.index) begin
                    $display("%0t: result_index expected %0d actual %0d", $realtime,
                             e.index, m_result_index);
                    errors++;
                end
                if (m_result_last !== e.last) begin
                    $display("%0t: result_last expected %0d actual %0d", $realtime,
                             e.last, m_result_last);
                    errors++;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Watchdog on cycles with no transaction of any kind
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("rsa_public_modexp_montgomery test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    row_t rows[$];

    initial begin
        logic [31:0]                 nv [64];
        logic [31:0]                 rv [64];
        logic [31:0]                 mv [64];
        int                          order [$];
        int                          cnt, sel, tmp, pos;
        logic [rsapm_pkg::CNT_W-1:0] wc;
        logic [31:0]                 mu;
        bit                          ex, partial;
        res_t                        r;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_word_index = '0;
        s_modulus_word = '0;
        s_rsquare_word = '0;
        s_message_word = '0;
        s_load_last = 1'b0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        items_sent = 0;
        idle_cycles = 0;
        tx_idle_pct = 35;
        rx_stall_pct = 48;
        wc_reg = rsapm_pkg::WC_RESET;
        mu_reg = rsapm_pkg::INV_RESET;
        exp_reg = rsapm_pkg::EXP_RESET;
        loaded = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part
        rows = '{
            // count 1, N = 1, zero message: zero result
            '{1, 7'd1, 32'd1, 1, 6'd0, 32'd1, 32'd0, 32'd0, 1, 1, 32'd0},
            // index beyond count is ignored, load_last too
            '{0, 7'd0, 32'd0, 0, 6'd1, 32'h5, 32'h5, 32'h5, 1, 0, 32'd0},
            '{0, 7'd0, 32'd0, 0, 6'd63, 32'h7, 32'h7, 32'h7, 0, 0, 32'd0},
            // count 0 acts as 1, all-ones operands, exponent 3
            '{1, 7'd0, 32'd1, 0, 6'd0, 32'hffffffff, 32'hffffffff, 32'hffffffff,
              1, 0, 32'd0},
            // two words, zero inverse
            '{1, 7'd2, 32'd0, 0, 6'd1, 32'h80000001, 32'h1234, 32'h0, 0, 0, 32'd0},
            '{0, 7'd0, 32'd0, 0, 6'd0, 32'hff00ff01, 32'h0, 32'hffffffff, 1, 0, 32'd0},
            // partial reload of one word
            '{0, 7'd0, 32'd0, 0, 6'd0, 32'hff00ff01, 32'h0, 32'h00ff00ff, 1, 0, 32'd0},
            // three words, all-ones inverse, exponent 65537
            '{1, 7'd3, 32'hffffffff, 1, 6'd2, 32'hffffffff, 32'h0, 32'h1, 0, 0, 32'd0},
            '{0, 7'd0, 32'd0, 0, 6'd0, 32'h1, 32'hffffffff, 32'h2, 0, 0, 32'd0},
            '{0, 7'd0, 32'd0, 0, 6'd1, 32'h0, 32'h3, 32'hffffffff, 1, 0, 32'd0},
            '{0, 7'd0, 32'd0, 0, 6'd2, 32'h7fffffff, 32'h8, 32'h9, 0, 0, 32'd0},
            '{0, 7'd0, 32'd0, 0, 6'd1, 32'h1, 32'h1, 32'h1, 1, 0, 32'd0},
            // count 1, N = 1, exponent 3: zero result
            '{1, 7'd1, 32'd1, 0, 6'd0, 32'd1, 32'd0, 32'd0, 1, 1, 32'd0}
        };
        foreach (rows[i]) begin
            if (rows[i].cfg) configure(rows[i].wc, rows[i].mu, rows[i].ex);
            send_load(rows[i].idx, rows[i].n, rows[i].r2, rows[i].msg, rows[i].last,
                      !rows[i].typed);
            if (rows[i].typed) begin
                r.word  = rows[i].exp_word;
                r.index = '0;
                r.last  = 1'b1;
                result_q.push_back(r);
            end
        end

        // Random operations
        while (items_sent < ITEM_TARGET) begin
            if (items_sent < ITEM_TARGET / 3) begin
                tx_idle_pct = 35;
                rx_stall_pct = 48;
            end else if (items_sent < 2 * ITEM_TARGET / 3) begin
                tx_idle_pct = 48;
                rx_stall_pct = 35;
            end else begin
                tx_idle_pct = 0;
                rx_stall_pct = 0;
            end
            sel = $urandom_range(39);
            if (sel == 0) wc = 7'd64;
            else if (sel == 1) wc = rsapm_pkg::CNT_W'($urandom_range(65, 127));
            else if (sel == 2) wc = 7'd0;
            else wc = rsapm_pkg::CNT_W'($urandom_range(1, 8));
            cnt = (wc == 0) ? 1 : (wc > 64) ? 64 : int'(wc);
            for (int k = 0; k < 64; k++) begin
                nv[k] = $urandom;
                rv[k] = $urandom;
                mv[k] = $urandom;
            end
            if ($urandom_range(9) != 0) nv[0][0] = 1'b1;
            mu = ($urandom_range(9) < 7) ? inv32(nv[0]) : $urandom;
            ex = $urandom_range(1);
            configure(wc, mu, ex);

            // Full load in shuffled order, or a partial reload when all present
            partial = ($urandom_range(9) < 3);
            for (int k = 0; k < cnt; k++) partial &= loaded[k];
            order.delete();
            for (int k = 0; k < cnt; k++) begin
                if (!partial || $urandom_range(1)) order.push_back(k);
            end
            for (int k = order.size() - 1; k > 0; k--) begin
                pos = $urandom_range(k);
                tmp = order[k];
                order[k] = order[pos];
                order[pos] = tmp;
            end
            foreach (order[i]) begin
                if (cnt < 64 && $urandom_range(9) < 2) begin
                    send_load(rsapm_pkg::IDX_W'($urandom_range(cnt, 63)), $urandom,
                              $urandom, $urandom, $urandom_range(1), 1);
                end
                send_load(rsapm_pkg::IDX_W'(order[i]), nv[order[i]], rv[order[i]],
                          mv[order[i]], 0, 1);
            end
            pos = $urandom_range(cnt - 1);
            send_load(rsapm_pkg::IDX_W'(pos), nv[pos], rv[pos], mv[pos], 1, 1);
        end

        s_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("rsa_public_modexp_montgomery test passed");
        end else begin
            $display("rsa_public_modexp_montgomery test failed");
        end
        $finish;
    end

endmodule
